[hdl/pps_pkg.sv]
// Shared types and constants of the preemptive priority scheduler.
// Used by pps_cell and preemptive_priority_scheduler; depends on nothing else.
package pps_pkg;

  // Table size and derived widths.
  localparam int SLOTS  = 16;
  localparam int IDX_W  = ($clog2(SLOTS) > 4) ? $clog2(SLOTS) : 4;
  localparam int CNT_W  = IDX_W + 1;
  localparam int TIME_W = 16;
  localparam int PRIO_W = 8;
  localparam int SLOT_W = 4;
  localparam int ACT_W  = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Operation codes carried in tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Saturation point of the count of unfinished tasks seen by the scan.
  localparam logic [1:0] LEFT_SAT = 2'd2;

  // Best candidate handed from cell to cell during a tick scan.
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  slot;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] burst;
    logic [1:0]        left;
  } token_t;

  // Slot write broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  slot;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] arrival;
    logic [PRIO_W-1:0] prio;
  } load_t;

  // Run-one-unit command broadcast to every cell.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] slot;
  } dec_t;

endpackage

[hdl/pps_cell.sv]
// One task slot of the scheduler: holds the task and judges the passing candidate.
// Depends on pps_pkg.
module pps_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [pps_pkg::IDX_W-1:0]    idx_i,
  input  logic [pps_pkg::ACT_W-1:0]    active_i,
  input  logic [pps_pkg::TIME_W-1:0]   now_i,
  input  pps_pkg::load_t               load_i,
  input  pps_pkg::dec_t                dec_i,
  input  logic                         tok_valid_i,
  input  pps_pkg::token_t              tok_i,
  output logic                         tok_valid_o,
  output pps_pkg::token_t              tok_o
);
  import pps_pkg::*;

  logic [TIME_W-1:0] remaining_q;
  logic [TIME_W-1:0] burst_q;
  logic [TIME_W-1:0] arrival_q;
  logic [PRIO_W-1:0] prio_q;
  logic              tok_valid_q;
  token_t            tok_q;
  token_t            tok_d;
  logic              in_use;
  logic              ready;
  logic              better;

  // Remaining time is the only slot state with a reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
    end else if (load_i.en && (load_i.slot == idx_i)) begin
      remaining_q <= load_i.burst;
    end else if (dec_i.en && (dec_i.slot == idx_i)) begin
      remaining_q <= remaining_q - TIME_W'(1);
    end
  end

  // Task description, valid once the slot has been loaded.
  always_ff @(posedge clk_i) begin
    if (load_i.en && (load_i.slot == idx_i)) begin
      burst_q   <= load_i.burst;
      arrival_q <= load_i.arrival;
      prio_q    <= load_i.prio;
    end
  end

  // Compare this slot against the candidate so far; earlier slots win ties.
  always_comb begin
    in_use = (CNT_W'(idx_i) < CNT_W'(active_i)) && (remaining_q != '0);
    ready  = in_use && (arrival_q <= now_i);
    better = ready && (!tok_i.found || (prio_q < tok_i.prio) ||
                       ((prio_q == tok_i.prio) && (arrival_q < tok_i.arrival)));
    tok_d = tok_i;
    if (better) begin
      tok_d.found     = 1'b1;
      tok_d.slot      = idx_i;
      tok_d.prio      = prio_q;
      tok_d.arrival   = arrival_q;
      tok_d.remaining = remaining_q;
      tok_d.burst     = burst_q;
    end
    if (in_use && (tok_i.left != LEFT_SAT)) begin
      tok_d.left = tok_i.left + 2'd1;
    end
  end

  // Hand the candidate to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_valid_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

[hdl/preemptive_priority_scheduler.sv]
// Top level of the preemptive priority scheduler: stream ports, clock and result register.
// Depends on pps_pkg and pps_cell.
//
// A load transaction (tuser 0) writes one task slot and yields no result. A tick
// transaction (tuser 1) sends a candidate through the row of SLOTS cells, one cell
// per cycle, each keeping the better of its own ready task and the one handed in;
// the tick then commits one unit of run time to the task chosen, if any, and time
// advances while an active task is unfinished. The result of a tick passes through
// the start register and the cell row into the output register, and the input
// accepts nothing while a tick is in progress, so a tick is taken only after the
// last one has committed. A result waiting in the output register still lets loads
// and one more tick in; that tick then holds the input until the register is read.
module preemptive_priority_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: active_slots.
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // slot[3:0], burst[19:4], arrival[35:20], prio[43:36]
  input  logic [0:0]  s_axis_tuser,  // op[0]
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // ran_valid[0], ran_slot[4:1], finished[5],
                                     // completion_time[21:6], turnaround[37:22],
                                     // waiting[53:38], all_done[54], now[70:55]
);
  import pps_pkg::*;

  logic [ACT_W-1:0]  active_q;
  logic [TIME_W-1:0] time_q;
  logic              busy_q;
  logic              start_q;
  logic              pend_q;
  logic              out_valid_q;
  logic [71:0]       out_data_q;

  logic              in_fire;
  logic              tick_fire;
  load_t             load;
  dec_t              dec;
  logic              tok_valid [SLOTS+1];
  token_t            tok       [SLOTS+1];
  token_t            fin;
  logic              scan_done;
  logic              commit;
  logic              any_left;
  logic              finished;
  logic              all_done;
  logic [TIME_W-1:0] now_next;
  logic [TIME_W-1:0] turn;
  logic [TIME_W-1:0] wait_t;
  logic [SLOT_W-1:0] ran_slot;
  logic [71:0]       out_data_d;

  assign s_axis_tready = !busy_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign tick_fire     = in_fire && (s_axis_tuser[0] == OP_TICK);

  // Slot writes go straight to the cells.
  always_comb begin
    load.en      = in_fire && (s_axis_tuser[0] == OP_LOAD);
    load.slot    = IDX_W'(s_axis_tdata[3:0]);
    load.burst   = s_axis_tdata[19:4];
    load.arrival = s_axis_tdata[35:20];
    load.prio    = s_axis_tdata[43:36];
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // Row of cells; an empty candidate enters at the head.
  assign tok_valid[0] = start_q;
  assign tok[0]       = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    pps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (IDX_W'(g)),
      .active_i    (active_q),
      .now_i       (time_q),
      .load_i      (load),
      .dec_i       (dec),
      .tok_valid_i (tok_valid[g]),
      .tok_i       (tok[g]),
      .tok_valid_o (tok_valid[g+1]),
      .tok_o       (tok[g+1])
    );
  end

  assign fin       = tok[SLOTS];
  assign scan_done = tok_valid[SLOTS] || pend_q;
  assign commit    = scan_done && (!out_valid_q || m_axis_tready);

  // Outcome of the tick from the candidate leaving the row.
  always_comb begin
    any_left = (fin.left != 2'd0);
    if (any_left && (time_q != TIME_MAX)) begin
      now_next = time_q + TIME_W'(1);
    end else begin
      now_next = time_q;
    end
    finished = fin.found && (fin.remaining == TIME_W'(1));
    if (fin.found) begin
      all_done = finished && (fin.left != LEFT_SAT);
    end else begin
      all_done = !any_left;
    end
    turn     = (now_next >= fin.arrival) ? (now_next - fin.arrival) : '0;
    wait_t   = (turn >= fin.burst) ? (turn - fin.burst) : '0;
    ran_slot = fin.found ? fin.slot[SLOT_W-1:0] : '0;
    dec.en   = commit && fin.found;
    dec.slot = fin.slot;

    out_data_d         = '0;
    out_data_d[0]      = fin.found;
    out_data_d[4:1]    = ran_slot;
    out_data_d[5]      = finished;
    out_data_d[21:6]   = finished ? now_next : '0;
    out_data_d[37:22]  = finished ? turn : '0;
    out_data_d[53:38]  = finished ? wait_t : '0;
    out_data_d[54]     = all_done;
    out_data_d[70:55]  = now_next;
  end

  // Tick sequencing, time and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      time_q      <= '0;
    end else begin
      start_q <= tick_fire;
      if (tick_fire) begin
        busy_q <= 1'b1;
      end
      if (commit) begin
        busy_q      <= 1'b0;
        pend_q      <= 1'b0;
        time_q      <= now_next;
        out_valid_q <= 1'b1;
      end else begin
        if (tok_valid[SLOTS]) begin
          pend_q <= 1'b1;
        end
        if (m_axis_tready) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A candidate leaves the row only while a tick is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni) tok_valid[SLOTS] |-> busy_q)
    else $error("scan finished with no tick in progress");

  // A completed task reports the current time as its completion time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[5]) |-> (m_axis_tdata[21:6] == m_axis_tdata[70:55]))
    else $error("completion time differs from current time");

  // Only a task that ran can finish.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[5]) |-> m_axis_tdata[0])
    else $error("finish reported on an idle tick");

  // Time moves only when a tick commits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(commit) |-> $stable(time_q))
    else $error("time changed outside a tick");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for preemptive_priority_scheduler: loads task slots, runs ticks
// and compares every result against an internal scheduler model. Depends on pps_pkg.
module tb_top;
  import pps_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int DRAIN_CYCLES = 2 * (SLOTS + 2) + 4;
  localparam int RANDOM_ITEMS = 1250;
  localparam int HOLD_CYCLES  = 600;

  // One tick result as the block reports it.
  typedef struct packed {
    logic              ran_valid;
    logic [SLOT_W-1:0] ran_slot;
    logic              finished;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
    logic [TIME_W-1:0] now;
  } sched_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [4:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // slot, burst, arrival, prio from the lowest bit up
  logic [0:0]  s_axis_tuser;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // ran_valid, ran_slot, finished, completion_time,
                               // turnaround, waiting, all_done, now

  // Scheduler model state.
  logic [TIME_W-1:0] task_left    [SLOTS];
  logic [TIME_W-1:0] task_burst   [SLOTS];
  logic [TIME_W-1:0] task_arrival [SLOTS];
  logic [PRIO_W-1:0] task_prio    [SLOTS];
  logic [TIME_W-1:0] clock_now;
  logic [ACT_W-1:0]  slots_enabled;

  sched_result_t expected_results[$];
  int err_count;
  int items_sent;
  int tx_burst_left;
  bit tx_idle_en;
  bit rx_stall_en;
  int rx_hold;

  preemptive_priority_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Scan the active slots, run the best ready task for one unit; advance time if any task is left.
  function automatic sched_result_t run_tick();
    sched_result_t r;
    int  n;
    int  best;
    bit  pending;
    bit  found;
    r       = '0;
    pending = 1'b0;
    found   = 1'b0;
    best    = 0;
    n = (slots_enabled < SLOTS) ? slots_enabled : SLOTS;
    for (int i = 0; i < n; i++) begin
      if (task_left[i] != '0) begin
        pending = 1'b1;
        if (task_arrival[i] <= clock_now &&
            (!found || task_prio[i] < task_prio[best] ||
             (task_prio[i] == task_prio[best] && task_arrival[i] < task_arrival[best]))) begin
          best  = i;
          found = 1'b1;
        end
      end
    end
    if (pending) begin
      if (clock_now != TIME_MAX) clock_now++;
      if (found) begin
        r.ran_valid = 1'b1;
        r.ran_slot  = best[SLOT_W-1:0];
        task_left[best]--;
        if (task_left[best] == '0) begin
          r.finished   = 1'b1;
          r.completion = clock_now;
          r.turnaround = (clock_now >= task_arrival[best]) ? clock_now - task_arrival[best] : '0;
          r.waiting    = (r.turnaround >= task_burst[best]) ? r.turnaround - task_burst[best]
                                                            : '0;
        end
      end
    end
    r.all_done = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (task_left[i] != '0) r.all_done = 1'b0;
    end
    r.now = clock_now;
    return r;
  endfunction

  function automatic sched_result_t unpack_result(input logic [71:0] d);
    sched_result_t r;
    r.ran_valid  = d[0];
    r.ran_slot   = d[4:1];
    r.finished   = d[5];
    r.completion = d[21:6];
    r.turnaround = d[37:22];
    r.waiting    = d[53:38];
    r.all_done   = d[54];
    r.now        = d[70:55];
    return r;
  endfunction

  function automatic string fmt_result(input sched_result_t r);
    return $sformatf("ran=%0d slot=%0d fin=%0d comp=%0d turn=%0d wait=%0d done=%0d now=%0d",
                     r.ran_valid, r.ran_slot, r.finished, r.completion, r.turnaround,
                     r.waiting, r.all_done, r.now);
  endfunction

  // Send one transaction, idling between bursts, and update the model once it is accepted.
  task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                           input logic [TIME_W-1:0] burst, input logic [TIME_W-1:0] arrival,
                           input logic [PRIO_W-1:0] prio);
    int gap;
    @(negedge clk_i);
    if (tx_burst_left <= 0) begin
      tx_burst_left = $urandom_range(1, 12);
      gap = tx_idle_en ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, prio, arrival, burst, slot};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tx_burst_left--;
    items_sent++;
    if (op == OP_LOAD) begin
      task_burst[slot]   = burst;
      task_arrival[slot] = arrival;
      task_prio[slot]    = prio;
      task_left[slot]    = burst;
    end else begin
      expected_results.push_back(run_tick());
    end
  endtask

  task automatic load_task(input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] burst,
                           input logic [TIME_W-1:0] arrival, input logic [PRIO_W-1:0] prio);
    send_item(OP_LOAD, slot, burst, arrival, prio);
  endtask

  task automatic tick();
    send_item(OP_TICK, '0, '0, '0, '0);
  endtask

  // Load a task with mostly short bursts, near arrivals and crowded priorities.
  task automatic random_load(input int slot_limit);
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] arrival;
    logic [PRIO_W-1:0] prio;
    int step;
    slot = ($urandom_range(0, 99) < 85) ? SLOT_W'($urandom_range(0, slot_limit - 1))
                                        : SLOT_W'($urandom_range(0, SLOTS - 1));
    case ($urandom_range(0, 9))
      0:       burst = '0;
      1:       burst = TIME_W'($urandom);
      default: burst = TIME_W'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 9))
      0: arrival = TIME_W'($urandom);
      1: arrival = TIME_W'($urandom_range(0, clock_now));
      default: begin
        step = clock_now + $urandom_range(0, 12);
        arrival = (step > TIME_MAX) ? TIME_MAX : step[TIME_W-1:0];
      end
    endcase
    prio = ($urandom_range(0, 9) < 3) ? PRIO_W'($urandom) : PRIO_W'($urandom_range(0, 3));
    load_task(slot, burst, arrival, prio);
  endtask

  // Stop offering, let every expected result arrive and the block settle.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    tx_burst_left = 0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_active(input logic [ACT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    slots_enabled = value;
  endtask

  // Ticks on an empty table, with no slots and with more slots than exist.
  task automatic test_empty_table();
    tick();
    wait_idle();
    write_active(0);
    tick();
    wait_idle();
    write_active(31);
    tick();
  endtask

  // Field extremes, nothing ready, tie breaks, zero bursts and preemption.
  task automatic test_directed_schedule();
    wait_idle();
    write_active(16);
    load_task(5, 16'hFFFF, 16'hFFFF, 8'h80);
    tick();
    load_task(15, 2, 0, 8'h00);
    load_task(0, 1, 0, 8'hFF);
    load_task(2, 1, 1, 7);
    load_task(1, 1, 1, 7);
    load_task(3, 1, 0, 7);
    repeat (7) tick();
    load_task(4, 0, 0, 0);
    load_task(5, 0, 0, 0);
    tick();
    load_task(6, 3, 0, 9);
    tick();
    load_task(7, 1, 0, 1);
    repeat (4) tick();
  endtask

  // A loaded slot outside the active window is not scheduled until the window grows.
  task automatic test_active_window();
    wait_idle();
    write_active(1);
    load_task(1, 1, 0, 0);
    tick();
    wait_idle();
    write_active(16);
    tick();
  endtask

  // The receiver holds off for a long stretch while ticks keep coming.
  task automatic test_backpressure();
    wait_idle();
    write_active(16);
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    for (int k = 0; k < 4; k++) load_task(SLOT_W'(k), 6, clock_now, PRIO_W'(k));
    rx_hold = HOLD_CYCLES;
    repeat (24) tick();
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  // Phases of random window size, random loads and mostly ticks.
  task automatic test_random_mix();
    int target;
    int lim;
    logic [ACT_W-1:0] act;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       act = 0;
        1:       act = ACT_W'($urandom_range(17, 31));
        2:       act = 16;
        default: act = ACT_W'($urandom_range(1, 16));
      endcase
      write_active(act);
      tx_idle_en  = ($urandom_range(0, 3) != 0);
      rx_stall_en = ($urandom_range(0, 3) != 0);
      lim = (act == 0) ? SLOTS : ((act < SLOTS) ? act : SLOTS);
      // Sometimes start the phase from an empty table.
      if ($urandom_range(0, 2) == 0) begin
        for (int k = 0; k < SLOTS; k++) begin
          load_task(SLOT_W'(k), 0, TIME_W'($urandom), PRIO_W'($urandom));
        end
      end
      repeat ($urandom_range(1, 5)) random_load(lim);
      repeat ($urandom_range(10, 40)) begin
        if ($urandom_range(0, 3) == 0) random_load(lim);
        else tick();
      end
    end
  endtask

  // Receiver: random stall runs, or a forced hold-off counted down here.
  initial begin
    bit rx_level;
    int rx_run;
    m_axis_tready = 1'b0;
    rx_level = 1'b1;
    rx_run   = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (!rx_stall_en) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (rx_run == 0) begin
          rx_level = !rx_level;
          rx_run   = rx_level ? $urandom_range(1, 12) : $urandom_range(1, 5);
        end
        rx_run--;
        m_axis_tready <= rx_level;
      end
    end
  end

  // Compare each accepted result with the oldest expected one.
  always @(posedge clk_i) begin : result_check
    sched_result_t got;
    sched_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = unpack_result(m_axis_tdata);
      if (expected_results.size() == 0) begin
        if (err_count < 10) $display("%0t: result with none expected: %s", $realtime,
                                     fmt_result(got));
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          if (err_count < 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
          err_count++;
        end
      end
    end
  end

  // Cycle limit for a hung run.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    err_count     = 0;
    items_sent    = 0;
    tx_burst_left = 0;
    tx_idle_en    = 1'b1;
    rx_stall_en   = 1'b1;
    rx_hold       = 0;
    clock_now     = '0;
    slots_enabled = '0;
    for (int i = 0; i < SLOTS; i++) begin
      task_left[i]    = '0;
      task_burst[i]   = '0;
      task_arrival[i] = '0;
      task_prio[i]    = '0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_directed_schedule();
    test_active_window();
    test_backpressure();
    test_random_mix();

    wait_idle();
    if (err_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
